@@ sv/b64u_pkg.sv @@
// ----------------------------------------------------------------------------
// b64u_pkg: shared types and helpers for the base64url codec
// Item structs, result-group struct, register indexes and the URL alphabet.
// ----------------------------------------------------------------------------
package b64u_pkg;

  localparam int CFG_IDX_W  = 1;
  localparam int MAX_RES    = 4;
  localparam int RES_CNT_W  = 3;
  localparam int RES_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_DECODE_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD_ENABLE  = 1'b1;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_has_data;
    logic       out_last;
    logic       out_stopped;
  } out_item_t;

  typedef struct packed {
    out_item_t [MAX_RES-1:0] items;
    logic [RES_CNT_W-1:0]    cnt;
  } res_grp_t;

  typedef struct packed {
    logic                 valid;
    logic [CFG_IDX_W-1:0] index;
    logic                 data;
  } cfg_wr_t;

  // 6-bit value to URL alphabet character
  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = 8'h2D;
    end else begin
      c = 8'h5F;
    end
    return c;
  endfunction

  // character to {valid, 6-bit value}
  function automatic logic [6:0] dec_char(input logic [7:0] c);
    logic [6:0] r;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = {1'b1, 6'(c - 8'h41)};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r = {1'b1, 6'(c - 8'h61 + 8'd26)};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 6'(c - 8'h30 + 8'd52)};
    end else if (c == 8'h2D) begin
      r = {1'b1, 6'd62};
    end else if (c == 8'h5F) begin
      r = {1'b1, 6'd63};
    end else begin
      r = 7'd0;
    end
    return r;
  endfunction

  function automatic out_item_t mk_res(input logic [7:0] b, input logic has,
                                       input logic stopped);
    out_item_t r;
    r.out_byte     = b;
    r.out_has_data = has;
    r.out_last     = 1'b0;
    r.out_stopped  = stopped;
    return r;
  endfunction

endpackage

@@ sv/b64u_core.sv @@
// ----------------------------------------------------------------------------
// b64u_core: codec state and per-item result group
// Holds the mode registers and bit accumulator; builds all results of one
// item combinationally and advances the state when the item is stepped.
// ----------------------------------------------------------------------------
module b64u_core
  import b64u_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  cfg_wr_t  cfg,
  input  in_item_t item,
  input  logic     step,
  output res_grp_t grp
);

  logic       decode_mode;
  logic       pad_enable;
  logic [5:0] bit_buffer;
  logic [2:0] pending_bits;
  logic       decode_halted;

  logic [5:0] bit_buffer_next;
  logic [2:0] pending_bits_next;
  logic       decode_halted_next;

  logic [7:0] b;
  logic [6:0] dv;
  logic [5:0] v;

  assign b  = item.in_byte;
  assign dv = dec_char(item.in_byte);
  assign v  = dv[5:0];

  always_comb begin
    grp                = '0;
    bit_buffer_next    = bit_buffer;
    pending_bits_next  = pending_bits;
    decode_halted_next = decode_halted;

    if (!decode_mode) begin
      case (pending_bits)
        3'd0: begin
          grp.items[0] = mk_res(enc_char(b[7:2]), 1'b1, 1'b0);
          grp.cnt      = 3'd1;
          if (item.in_last) begin
            grp.items[1] = mk_res(enc_char({b[1:0], 4'b0000}), 1'b1, 1'b0);
            grp.cnt      = 3'd2;
            if (pad_enable) begin
              grp.items[2] = mk_res(PAD_CHAR, 1'b1, 1'b0);
              grp.items[3] = mk_res(PAD_CHAR, 1'b1, 1'b0);
              grp.cnt      = 3'd4;
            end
          end
          bit_buffer_next   = {4'b0000, b[1:0]};
          pending_bits_next = 3'd2;
        end
        3'd2: begin
          grp.items[0] = mk_res(enc_char({bit_buffer[1:0], b[7:4]}), 1'b1, 1'b0);
          grp.cnt      = 3'd1;
          if (item.in_last) begin
            grp.items[1] = mk_res(enc_char({b[3:0], 2'b00}), 1'b1, 1'b0);
            grp.cnt      = 3'd2;
            if (pad_enable) begin
              grp.items[2] = mk_res(PAD_CHAR, 1'b1, 1'b0);
              grp.cnt      = 3'd3;
            end
          end
          bit_buffer_next   = {2'b00, b[3:0]};
          pending_bits_next = 3'd4;
        end
        default: begin
          grp.items[0] = mk_res(enc_char({bit_buffer[3:0], b[7:6]}), 1'b1, 1'b0);
          grp.items[1] = mk_res(enc_char(b[5:0]), 1'b1, 1'b0);
          grp.cnt      = 3'd2;
          bit_buffer_next   = 6'd0;
          pending_bits_next = 3'd0;
        end
      endcase
    end else begin
      if (!decode_halted) begin
        if (!dv[6]) begin
          decode_halted_next = 1'b1;
        end else begin
          case (pending_bits)
            3'd0: begin
              bit_buffer_next   = v;
              pending_bits_next = 3'd6;
            end
            3'd2: begin
              grp.items[0]      = mk_res({bit_buffer[1:0], v}, 1'b1, 1'b0);
              grp.cnt           = 3'd1;
              bit_buffer_next   = 6'd0;
              pending_bits_next = 3'd0;
            end
            3'd4: begin
              grp.items[0]      = mk_res({bit_buffer[3:0], v[5:2]}, 1'b1, 1'b0);
              grp.cnt           = 3'd1;
              bit_buffer_next   = {4'b0000, v[1:0]};
              pending_bits_next = 3'd2;
            end
            default: begin
              grp.items[0]      = mk_res({bit_buffer, v[5:4]}, 1'b1, 1'b0);
              grp.cnt           = 3'd1;
              bit_buffer_next   = {2'b00, v[3:0]};
              pending_bits_next = 3'd4;
            end
          endcase
        end
      end
      // end marker when the last item yields no byte
      if (item.in_last && grp.cnt == 3'd0) begin
        grp.items[0] = mk_res(8'h00, 1'b0, decode_halted_next);
        grp.cnt      = 3'd1;
      end
    end

    if (item.in_last) begin
      bit_buffer_next    = 6'd0;
      pending_bits_next  = 3'd0;
      decode_halted_next = 1'b0;
    end

    // flag the final result of the message
    for (int i = 0; i < MAX_RES; i++) begin
      grp.items[i].out_last = item.in_last && (RES_CNT_W'(i) == grp.cnt - 3'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      decode_mode   <= 1'b0;
      pad_enable    <= 1'b1;
      bit_buffer    <= 6'd0;
      pending_bits  <= 3'd0;
      decode_halted <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_DECODE_MODE: begin
          decode_mode   <= cfg.data;
          bit_buffer    <= 6'd0;
          pending_bits  <= 3'd0;
          decode_halted <= 1'b0;
        end
        CFG_PAD_ENABLE: begin
          pad_enable <= cfg.data;
        end
        default: begin
        end
      endcase
    end else if (step) begin
      bit_buffer    <= bit_buffer_next;
      pending_bits  <= pending_bits_next;
      decode_halted <= decode_halted_next;
    end
  end

endmodule

@@ sv/b64u_out_ser.sv @@
// ----------------------------------------------------------------------------
// b64u_out_ser: result group register and output serializer
// Holds the results of one item and hands them out one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module b64u_out_ser
  import b64u_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  res_grp_t  grp,
  output logic      free,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic                 busy;
  logic [RES_IDX_W-1:0] idx;
  logic [RES_CNT_W-1:0] cnt;
  out_item_t            entries [MAX_RES];
  logic                 at_end;

  assign at_end    = ({1'b0, idx} == cnt - 3'd1);
  assign free      = !busy || (out_ready && at_end);
  assign out_valid = busy;
  assign out_data  = entries[idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
      cnt  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= '0;
      cnt  <= grp.cnt;
    end else if (busy && out_ready) begin
      if (at_end) begin
        busy <= 1'b0;
      end
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < MAX_RES; i++) begin
        entries[i] <= grp.items[i];
      end
    end
  end

endmodule

@@ sv/base64url_codec_unit.sv @@
// ----------------------------------------------------------------------------
// base64url_codec_unit: streaming base64url encoder / decoder
// One byte per request in, one character or byte per request out.
// ----------------------------------------------------------------------------
// An input request is taken into an input register, then all of its results
// (up to four) are built in one pass and loaded into a result group that is
// sent out one per cycle while out_ready is high. While results drain, the
// input register can hold one more request; it steps once the group frees on
// its last result, so throughput is set by the output port. Items that give
// no result (decode of a character that completes no byte) step without
// loading the result group. The first result of a request comes from the
// result group register, which is loaded from the input register.
// Write registers only while no message is in flight.
module base64url_codec_unit
  import b64u_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic                 cfg_data
);

  logic     inq_valid;
  in_item_t inq_item;
  res_grp_t grp;
  logic     ser_free;
  logic     step;
  cfg_wr_t  cfg;

  assign cfg_ready = 1'b1;
  assign cfg.valid = cfg_valid;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  // advance when the group has no results or the serializer can take it
  assign step     = inq_valid && (grp.cnt == 3'd0 || ser_free);
  assign in_ready = !inq_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid <= 1'b0;
    end else if (in_ready) begin
      inq_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      inq_item <= in_data;
    end
  end

  b64u_core u_core (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .item (inq_item),
    .step (step),
    .grp  (grp)
  );

  b64u_out_ser u_ser (
    .clk       (clk),
    .rst       (rst),
    .load      (step && grp.cnt != 3'd0),
    .grp       (grp),
    .free      (ser_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTH
  // an empty result is only ever an end marker
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.out_has_data |-> out_data.out_last)
    else $error("empty result without last flag");

  // stopped flag appears only on an empty end marker
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.out_stopped |-> !out_data.out_has_data)
    else $error("stopped flag on a data result");

  // a held input register keeps its request
  assert property (@(posedge clk) disable iff (rst)
    inq_valid && !in_ready |=> inq_valid && $stable(inq_item))
    else $error("input register lost a held request");
`endif

endmodule
